FILE: src/lzhd_pkg.sv
// Shared constants, types and helper functions of the adaptive Huffman LZSS decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzhd_pkg;

  // Window and alphabet geometry
  localparam int unsigned WinSize   = 4096;
  localparam int unsigned MaxMatch  = 30;
  localparam int unsigned SymCount  = 256 - 2 + MaxMatch;
  localparam int unsigned NodeCount = SymCount * 2 - 1;
  localparam int unsigned RootNode  = NodeCount - 1;
  localparam int unsigned LinkCount = NodeCount + SymCount;
  localparam int unsigned LitCount  = 256;
  localparam int unsigned LenBias   = 253;

  // Widths
  localparam int unsigned IdxW   = $clog2(LinkCount);
  localparam int unsigned SymW   = $clog2(SymCount);
  localparam int unsigned WinAw  = $clog2(WinSize);
  localparam int unsigned FreqW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = $clog2(MaxMatch + 1);
  localparam int unsigned CntW   = 32;
  localparam int unsigned BitsW  = CntW + 3;
  localparam int unsigned LeftW  = 4;

  // Fixed values
  localparam logic [FreqW-1:0] FreqLimit = 16'h8000;
  localparam logic [FreqW-1:0] FreqTop   = 16'hffff;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;
  localparam logic [WinAw-1:0] WposReset = WinAw'(WinSize - MaxMatch);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegTotalLength = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCompLength  = 1'b1;

  // Bit-stream phase
  typedef enum logic [1:0] {
    PhSymbol,
    PhByte,
    PhExtra
  } phase_e;

  // Upper distance bits and count of lower bits still to read
  typedef struct packed {
    logic [5:0]       hi;
    logic [LeftW-1:0] extra;
  } pos_split_t;

  // Prefix code for the upper six distance bits
  function automatic pos_split_t split_byte(input logic [ByteW-1:0] b);
    pos_split_t r;
    logic [ByteW-1:0] t;
    t = '0;
    if (b < 8'd32) begin
      r.hi = 6'd0;
      r.extra = 4'd1;
    end else if (b < 8'd80) begin
      t = 8'd1 + ((b - 8'd32) >> 4);
      r.hi = t[5:0];
      r.extra = 4'd2;
    end else if (b < 8'd144) begin
      t = 8'd4 + ((b - 8'd80) >> 3);
      r.hi = t[5:0];
      r.extra = 4'd3;
    end else if (b < 8'd192) begin
      t = 8'd12 + ((b - 8'd144) >> 2);
      r.hi = t[5:0];
      r.extra = 4'd4;
    end else if (b < 8'd240) begin
      t = 8'd24 + ((b - 8'd192) >> 1);
      r.hi = t[5:0];
      r.extra = 4'd5;
    end else begin
      t = 8'd48 + (b - 8'd240);
      r.hi = t[5:0];
      r.extra = 4'd6;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/lzhd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lzhd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write, then registered read (read-before-write on a collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/lzss_adaptive_huffman_decoder.sv
// Top level: bit-serial adaptive Huffman LZSS decoder built around four state RAMs.
`timescale 1ns / 1ps
`default_nettype none

// Takes one compressed bit per input transaction and returns decoded bytes, one per output
// transaction. Tree frequencies, child links, parent links and the 4 KiB history window
// live in single-read, single-write RAMs, and one sequencer does all read-modify-write
// work, so items are handled one at a time. A bit that completes a symbol adds the tree
// update: a climb over the ancestor levels, with a node swap and a search for the swap
// target where a count passes its neighbour, and the window and output write for a literal
// byte. A match is copied byte by byte with a window read and a write, and the copy waits
// while the output is stalled. When the root count reaches 0x8000 the tree is rebuilt,
// and the new internal nodes are put in place by a sorted insertion that shifts nodes
// as needed. After reset the block first clears the window and the tree RAMs and builds
// the initial tree with the same rebuild sequence; input is not taken during that time,
// configuration writes are.

module lzss_adaptive_huffman_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lzhd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lzhd_pkg::CntW-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           in_bit_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [lzhd_pkg::ByteW-1:0]     out_byte_o,
  output logic                                last_of_run_o,
  output logic                                stream_done_o
);

  import lzhd_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_WALK, S_ROOT, S_ROOTW,
    S_BUMP0, S_BUMP1, S_PAR, S_PARW, S_CHK, S_INC, S_CMP, S_SRCH, S_SRCHW,
    S_SW0, S_SW1, S_SW2, S_SW3, S_SW4, S_SW5, S_SW6, S_UP, S_UPW,
    S_LIT, S_MRD, S_MWR,
    S_R1A, S_R1B, S_R2A, S_R2B, S_R2C, S_R2D, S_R2E, S_R2F, S_R3A, S_R3B, S_R3C
  } state_e;

  localparam logic [IdxW-1:0] NodeIdx = IdxW'(NodeCount);
  localparam logic [IdxW-1:0] RootIdx = IdxW'(RootNode);
  localparam logic [IdxW-1:0] LinkIdx = IdxW'(LinkCount);
  localparam logic [IdxW-1:0] SymIdx  = IdxW'(SymCount);

  state_e             state_q;
  logic               init_q;
  logic [WinAw-1:0]   clr_q;
  logic [CntW-1:0]    total_q, comp_q, bytes_q;
  logic [BitsW-1:0]   bits_q;
  phase_e             phase_q;
  logic [IdxW-1:0]    walk_q;
  logic [WinAw-1:0]   pshift_q, wpos_q, src_q;
  logic [LeftW-1:0]   pleft_q;
  logic [LenW-1:0]    plen_q, mleft_q;
  logic [SymW-1:0]    sym_q;
  logic               sym_valid_q;
  logic [IdxW-1:0]    c_q, l_q, a_q, b_q, i_q, j_q, m_q, rk_q;
  logic [FreqW:0]     k_q, f_q;
  logic               out_valid_q, out_last_q, out_done_q;
  logic [ByteW-1:0]   out_byte_q;

  // RAM ports
  logic               freq_we, child_we, par_we, win_we;
  logic [IdxW-1:0]    freq_waddr, freq_raddr, child_waddr, child_raddr;
  logic [IdxW-1:0]    par_waddr, par_raddr;
  logic [FreqW-1:0]   freq_wdata, freq_rdata;
  logic [IdxW-1:0]    child_wdata, child_rdata, par_wdata, par_rdata;
  logic [WinAw-1:0]   win_waddr, win_raddr;
  logic [ByteW-1:0]   win_wdata, win_rdata;

  // Helpers
  logic               bit_eff, stream_end, slot_free;
  logic [IdxW:0]      walk_sum;
  logic [CntW-1:0]    bytes_nx;
  logic [BitsW-1:0]   bits_nx;
  logic [LeftW-1:0]   left_nx;
  logic [ByteW-1:0]   sh8;
  logic [WinAw-1:0]   ps_nx;
  logic [FreqW:0]     k_calc, rb_half;
  logic [IdxW-1:0]    sym_raw;
  pos_split_t         sp;

  assign stream_end = bytes_q >= total_q;
  assign bit_eff    = in_bit_i & (bits_q < {comp_q, 3'b000});
  assign bits_nx    = (bits_q == '1) ? bits_q : bits_q + BitsW'(1);
  assign bytes_nx   = (bytes_q == '1) ? bytes_q : bytes_q + CntW'(1);
  assign walk_sum   = {1'b0, walk_q} + (IdxW + 1)'(bit_eff);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign left_nx    = (pleft_q == '0) ? '0 : pleft_q - LeftW'(1);
  assign sh8        = {pshift_q[ByteW-2:0], bit_eff};
  assign ps_nx      = {pshift_q[WinAw-1:6], pshift_q[4:0], bit_eff};
  assign sp         = split_byte(sh8);
  assign k_calc     = {1'b0, freq_rdata} + (FreqW + 1)'(1);
  assign rb_half    = ({1'b0, freq_rdata} + (FreqW + 1)'(1)) >> 1;
  assign sym_raw    = child_rdata - NodeIdx;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign stream_done_o = out_done_q;

  // RAM address and write control per sequencer step
  always_comb begin
    freq_we = 1'b0; freq_waddr = '0; freq_wdata = '0; freq_raddr = '0;
    child_we = 1'b0; child_waddr = '0; child_wdata = '0; child_raddr = '0;
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = '0;
    win_we = 1'b0; win_waddr = wpos_q; win_wdata = SpaceByte; win_raddr = src_q;
    case (state_q)
      S_CLEAR: begin
        win_we      = 1'b1;
        win_waddr   = clr_q;
        freq_we     = clr_q < WinAw'(NodeCount + 1);
        freq_waddr  = clr_q[IdxW-1:0];
        freq_wdata  = (clr_q == WinAw'(NodeCount)) ? FreqTop : FreqW'(1);
        child_we    = clr_q < WinAw'(NodeCount);
        child_waddr = clr_q[IdxW-1:0];
        child_wdata = (clr_q < WinAw'(SymCount)) ? clr_q[IdxW-1:0] + NodeIdx : '0;
        par_we      = clr_q < WinAw'(LinkCount);
        par_waddr   = clr_q[IdxW-1:0];
      end
      S_IDLE:  child_raddr = walk_sum[IdxW-1:0];
      S_ROOT:  child_raddr = RootIdx;
      S_BUMP0: freq_raddr = RootIdx;
      S_PAR:   par_raddr = IdxW'(sym_q) + NodeIdx;
      S_CHK:   freq_raddr = c_q;
      S_INC: begin
        freq_we    = 1'b1;
        freq_waddr = c_q;
        freq_wdata = k_calc[FreqW-1:0];
        freq_raddr = c_q + IdxW'(1);
      end
      S_SRCH:  freq_raddr = l_q + IdxW'(1);
      S_SW0:   freq_raddr = l_q;
      S_SW1: begin
        freq_we     = 1'b1;
        freq_waddr  = c_q;
        freq_wdata  = freq_rdata;
        child_raddr = c_q;
      end
      S_SW2: begin
        freq_we     = 1'b1;
        freq_waddr  = l_q;
        freq_wdata  = k_q[FreqW-1:0];
        child_raddr = l_q;
      end
      S_SW3: begin
        child_we    = 1'b1;
        child_waddr = l_q;
        child_wdata = a_q;
        par_we      = a_q < LinkIdx;
        par_waddr   = a_q;
        par_wdata   = l_q;
      end
      S_SW4: begin
        child_we    = 1'b1;
        child_waddr = c_q;
        child_wdata = b_q;
        par_we      = a_q < NodeIdx;
        par_waddr   = a_q + IdxW'(1);
        par_wdata   = l_q;
      end
      S_SW5: begin
        par_we    = b_q < LinkIdx;
        par_waddr = b_q;
        par_wdata = c_q;
      end
      S_SW6: begin
        par_we    = b_q < NodeIdx;
        par_waddr = b_q + IdxW'(1);
        par_wdata = c_q;
      end
      S_UP:    par_raddr = c_q;
      S_LIT: begin
        win_we    = slot_free;
        win_wdata = sym_q[ByteW-1:0];
      end
      S_MWR: begin
        win_we    = slot_free;
        win_wdata = win_rdata;
      end
      S_R1A: begin
        freq_raddr  = i_q;
        child_raddr = i_q;
      end
      S_R1B: begin
        freq_we     = child_rdata >= NodeIdx;
        freq_waddr  = j_q;
        freq_wdata  = rb_half[FreqW-1:0];
        child_we    = child_rdata >= NodeIdx;
        child_waddr = j_q;
        child_wdata = child_rdata;
      end
      S_R2A:   freq_raddr = i_q;
      S_R2B:   freq_raddr = i_q + IdxW'(1);
      S_R2D: begin
        freq_raddr  = m_q;
        child_raddr = m_q;
      end
      S_R2E: begin
        freq_we     = 1'b1;
        child_we    = 1'b1;
        freq_waddr  = m_q + IdxW'(1);
        child_waddr = m_q + IdxW'(1);
        if (f_q < {1'b0, freq_rdata}) begin
          freq_wdata  = freq_rdata;
          child_wdata = child_rdata;
        end else begin
          freq_wdata  = f_q[FreqW-1:0];
          child_wdata = i_q;
        end
      end
      S_R2F: begin
        freq_we     = 1'b1;
        child_we    = 1'b1;
        freq_wdata  = f_q[FreqW-1:0];
        child_wdata = i_q;
      end
      S_R3A:   child_raddr = i_q;
      S_R3B: begin
        par_we    = child_rdata < LinkIdx;
        par_waddr = child_rdata;
        par_wdata = i_q;
      end
      S_R3C: begin
        par_we    = 1'b1;
        par_waddr = rk_q + IdxW'(1);
        par_wdata = i_q;
      end
      default: ;
    endcase
  end

  // Sequencer, bit-stream state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      total_q     <= '0;
      comp_q      <= '0;
      bytes_q     <= '0;
      bits_q      <= '0;
      phase_q     <= PhSymbol;
      walk_q      <= '0;
      pshift_q    <= '0;
      pleft_q     <= '0;
      plen_q      <= '0;
      mleft_q     <= '0;
      wpos_q      <= WposReset;
      src_q       <= '0;
      sym_q       <= '0;
      sym_valid_q <= 1'b0;
      c_q         <= '0;
      l_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      rk_q        <= '0;
      k_q         <= '0;
      f_q         <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      // configuration transactions
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTotalLength: total_q <= cfg_data_i;
          RegCompLength:  comp_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // window fill and tree RAM preset, then initial build
        S_CLEAR: begin
          clr_q <= clr_q + WinAw'(1);
          if (clr_q == '1) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_R1A;
          end
        end

        S_IDLE: begin
          if (in_valid_i && !stream_end) begin
            bits_q <= bits_nx;
            case (phase_q)
              PhByte: begin
                pleft_q <= left_nx;
                if (left_nx == '0) begin
                  pshift_q <= {sp.hi, sh8[5:0]};
                  pleft_q  <= sp.extra;
                  phase_q  <= PhExtra;
                end else begin
                  pshift_q <= WinAw'(sh8);
                end
              end
              PhExtra: begin
                pshift_q <= ps_nx;
                pleft_q  <= left_nx;
                if (left_nx == '0) begin
                  src_q    <= wpos_q - ps_nx - WinAw'(1);
                  mleft_q  <= plen_q;
                  plen_q   <= '0;
                  pshift_q <= '0;
                  phase_q  <= PhSymbol;
                  if (plen_q != '0) begin
                    state_q <= S_MRD;
                  end
                end
              end
              default: begin
                phase_q <= PhSymbol;
                if (walk_sum >= (IdxW + 1)'(NodeCount)) begin
                  sym_valid_q <= 1'b0;
                  state_q     <= S_ROOT;
                end else begin
                  state_q <= S_WALK;
                end
              end
            endcase
          end
        end

        // one tree edge
        S_WALK: begin
          if (child_rdata < NodeIdx) begin
            walk_q  <= child_rdata;
            state_q <= S_IDLE;
          end else begin
            sym_q       <= (sym_raw >= SymIdx) ? SymW'(SymCount - 1) : sym_raw[SymW-1:0];
            sym_valid_q <= 1'b1;
            state_q     <= S_BUMP0;
          end
        end

        S_ROOT: state_q <= S_ROOTW;
        S_ROOTW: begin
          walk_q      <= child_rdata;
          sym_valid_q <= 1'b0;
          state_q     <= S_IDLE;
          if (sym_valid_q) begin
            if (sym_q < SymW'(LitCount)) begin
              state_q <= S_LIT;
            end else begin
              phase_q  <= PhByte;
              pshift_q <= '0;
              pleft_q  <= LeftW'(8);
              plen_q   <= LenW'(sym_q - SymW'(LenBias));
            end
          end
        end

        // frequency update: rebuild check, then climb from the leaf
        S_BUMP0: state_q <= S_BUMP1;
        S_BUMP1: begin
          if (freq_rdata == FreqLimit) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_R1A;
          end else begin
            state_q <= S_PAR;
          end
        end
        S_PAR:  state_q <= S_PARW;
        S_PARW: begin
          c_q     <= par_rdata;
          state_q <= S_CHK;
        end
        S_CHK:  state_q <= (c_q >= NodeIdx) ? S_ROOT : S_INC;
        S_INC: begin
          k_q     <= k_calc;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (k_q > {1'b0, freq_rdata}) begin
            l_q     <= c_q + IdxW'(1);
            state_q <= S_SRCH;
          end else begin
            state_q <= S_UP;
          end
        end
        S_SRCH: begin
          if (l_q < NodeIdx) begin
            state_q <= S_SRCHW;
          end else begin
            l_q     <= RootIdx;
            state_q <= S_SW0;
          end
        end
        S_SRCHW: begin
          if (k_q > {1'b0, freq_rdata}) begin
            l_q     <= l_q + IdxW'(1);
            state_q <= S_SRCH;
          end else begin
            state_q <= S_SW0;
          end
        end

        // node swap
        S_SW0: state_q <= S_SW1;
        S_SW1: state_q <= S_SW2;
        S_SW2: begin
          a_q     <= child_rdata;
          state_q <= S_SW3;
        end
        S_SW3: begin
          b_q     <= child_rdata;
          state_q <= S_SW4;
        end
        S_SW4: state_q <= S_SW5;
        S_SW5: state_q <= S_SW6;
        S_SW6: begin
          c_q     <= l_q;
          state_q <= S_UP;
        end
        S_UP:  state_q <= S_UPW;
        S_UPW: begin
          c_q     <= par_rdata;
          state_q <= (par_rdata == '0) ? S_ROOT : S_CHK;
        end

        // literal byte
        S_LIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= sym_q[ByteW-1:0];
            out_last_q  <= 1'b1;
            out_done_q  <= bytes_nx >= total_q;
            bytes_q     <= bytes_nx;
            wpos_q      <= wpos_q + WinAw'(1);
            state_q     <= S_IDLE;
          end
        end

        // match copy, one byte per read and write
        S_MRD: state_q <= S_MWR;
        S_MWR: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= win_rdata;
            out_last_q  <= (mleft_q == LenW'(1));
            out_done_q  <= bytes_nx >= total_q;
            bytes_q     <= bytes_nx;
            wpos_q      <= wpos_q + WinAw'(1);
            src_q       <= src_q + WinAw'(1);
            mleft_q     <= mleft_q - LenW'(1);
            state_q     <= (mleft_q == LenW'(1)) ? S_IDLE : S_MRD;
          end
        end

        // rebuild: gather leaves with halved counts
        S_R1A: state_q <= S_R1B;
        S_R1B: begin
          if (child_rdata >= NodeIdx) begin
            j_q <= j_q + IdxW'(1);
          end
          if (i_q == RootIdx) begin
            i_q     <= '0;
            j_q     <= SymIdx;
            state_q <= S_R2A;
          end else begin
            i_q     <= i_q + IdxW'(1);
            state_q <= S_R1A;
          end
        end

        // rebuild: pair nodes, insertion into sorted order
        S_R2A: state_q <= S_R2B;
        S_R2B: begin
          f_q     <= {1'b0, freq_rdata};
          state_q <= S_R2C;
        end
        S_R2C: begin
          f_q     <= f_q + {1'b0, freq_rdata};
          m_q     <= j_q - IdxW'(1);
          state_q <= S_R2D;
        end
        S_R2D: state_q <= S_R2E;
        S_R2E: begin
          if (f_q < {1'b0, freq_rdata}) begin
            if (m_q == '0) begin
              state_q <= S_R2F;
            end else begin
              m_q     <= m_q - IdxW'(1);
              state_q <= S_R2D;
            end
          end else if (j_q == RootIdx) begin
            i_q     <= '0;
            state_q <= S_R3A;
          end else begin
            i_q     <= i_q + IdxW'(2);
            j_q     <= j_q + IdxW'(1);
            state_q <= S_R2A;
          end
        end
        S_R2F: begin
          if (j_q == RootIdx) begin
            i_q     <= '0;
            state_q <= S_R3A;
          end else begin
            i_q     <= i_q + IdxW'(2);
            j_q     <= j_q + IdxW'(1);
            state_q <= S_R2A;
          end
        end

        // rebuild: parent links; after the initial build, load the walk start
        S_R3A: state_q <= S_R3B;
        S_R3B, S_R3C: begin
          if (state_q == S_R3B && child_rdata < NodeIdx) begin
            rk_q    <= child_rdata;
            state_q <= S_R3C;
          end else if (i_q == RootIdx) begin
            init_q  <= 1'b0;
            state_q <= init_q ? S_ROOT : S_PAR;
          end else begin
            i_q     <= i_q + IdxW'(1);
            state_q <= S_R3A;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // State RAMs
  lzhd_ram #(.Width(FreqW), .Depth(NodeCount + 1)) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (freq_we),
    .waddr_i (freq_waddr),
    .wdata_i (freq_wdata),
    .raddr_i (freq_raddr),
    .rdata_o (freq_rdata)
  );

  lzhd_ram #(.Width(IdxW), .Depth(NodeCount)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  lzhd_ram #(.Width(IdxW), .Depth(LinkCount)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  lzhd_ram #(.Width(ByteW), .Depth(WinSize)) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

`ifndef SYNTHESIS
  // a decoded byte enters the window only when the output register can take it
  a_win_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_we && state_q != S_CLEAR) |-> slot_free)
    else $error("window write without a free output slot");

  // a swap always moves the node to a higher, valid index
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW0) |-> (l_q > c_q && l_q < NodeIdx))
    else $error("swap target out of order");

  // no input is taken before the initial tree exists
  a_ready_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !init_q)
    else $error("input ready during initialization");

  // every copied byte advances the byte count by one until the count saturates
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MWR && slot_free && bytes_q != '1) |=> (bytes_q == $past(bytes_q) + 1'b1))
    else $error("byte count did not advance");
`endif

endmodule

`default_nettype wire

FILE: bench/lzhd_checker.sv
// Scoreboard for the adaptive Huffman LZSS decoder: predicts decoded bytes and compares them.
`timescale 1ns / 1ps

module lzhd_checker
  import lzhd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CntW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               in_bit_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [ByteW-1:0]   out_byte_i,
  input  wire logic               last_of_run_i,
  input  wire logic               stream_done_i,
  output int                      pending_o,
  output int                      bytes_seen_o,
  output int                      errors_o
);

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    logic             done;
  } decoded_byte_t;

  decoded_byte_t byte_q[$];

  // Predicted decoder state
  logic [FreqW-1:0] freq [NodeCount+1];
  logic [IdxW-1:0]  son  [NodeCount];
  logic [IdxW-1:0]  prnt [LinkCount];
  logic [ByteW-1:0] hist [WinSize];
  logic [WinAw-1:0] wpos;
  logic [IdxW-1:0]  walk;
  phase_e           phase;
  logic [15:0]      pos_sh;
  logic [LeftW-1:0] pos_left;
  logic [LenW-1:0]  match_len;
  logic [CntW-1:0]  n_out;
  logic [BitsW-1:0] n_bits;
  logic [CntW-1:0]  total_len;
  logic [CntW-1:0]  comp_len;

  function automatic void link_up(int unsigned idx, int unsigned val);
    if (idx < LinkCount) prnt[idx] = IdxW'(val);
  endfunction

  function automatic void init_tree();
    int unsigned j;
    for (int unsigned i = 0; i < LinkCount; i++) prnt[i] = '0;
    for (int unsigned i = 0; i < SymCount; i++) begin
      freq[i] = 16'd1;
      son[i] = IdxW'(i + NodeCount);
      prnt[i + NodeCount] = IdxW'(i);
    end
    j = SymCount;
    for (int unsigned i = 0; j <= RootNode; i += 2, j++) begin
      freq[j] = freq[i] + freq[i+1];
      son[j] = IdxW'(i);
      prnt[i] = IdxW'(j);
      prnt[i+1] = IdxW'(j);
    end
    freq[NodeCount] = FreqTop;
    prnt[RootNode] = '0;
    for (int unsigned i = 0; i < WinSize; i++) hist[i] = SpaceByte;
    wpos = WposReset;
    walk = son[RootNode];
    phase = PhSymbol;
    pos_sh = '0;
    pos_left = '0;
    match_len = '0;
    n_out = '0;
    n_bits = '0;
    total_len = '0;
    comp_len = '0;
  endfunction

  // Halve leaf counts and re-pair the tree
  function automatic void rebuild();
    int unsigned j, k, f;
    j = 0;
    for (int unsigned i = 0; i < NodeCount; i++) begin
      if (son[i] >= NodeCount) begin
        freq[j] = 16'((32'(freq[i]) + 1) / 2);
        son[j] = son[i];
        j++;
      end
    end
    j = SymCount;
    for (int unsigned i = 0; j < NodeCount; i += 2, j++) begin
      f = 32'(freq[i]) + 32'(freq[i+1]);
      k = j;
      while (k > 0 && f < freq[k-1]) k--;
      for (int unsigned m = j; m > k; m--) begin
        freq[m] = freq[m-1];
        son[m] = son[m-1];
      end
      freq[k] = 16'(f);
      son[k] = IdxW'(i);
    end
    for (int unsigned i = 0; i < NodeCount; i++) begin
      k = son[i];
      link_up(k, i);
      if (k < NodeCount) link_up(k + 1, i);
    end
  endfunction

  // Count one more occurrence of a symbol, swapping nodes to keep counts ordered
  function automatic void count_symbol(int unsigned sym);
    int unsigned c, k, l, a, b, guard;
    guard = 0;
    if (freq[RootNode] == FreqLimit) rebuild();
    c = prnt[sym + NodeCount];
    do begin
      if (c >= NodeCount || guard > LinkCount) break;
      guard++;
      k = 32'(freq[c]) + 1;
      freq[c] = 16'(k);
      if (k > freq[c+1]) begin
        l = c + 1;
        while (l + 1 <= NodeCount && k > freq[l+1]) l++;
        if (l >= NodeCount) l = NodeCount - 1;
        freq[c] = freq[l];
        freq[l] = 16'(k);
        a = son[c];
        link_up(a, l);
        if (a < NodeCount) link_up(a + 1, l);
        b = son[l];
        son[l] = IdxW'(a);
        link_up(b, c);
        if (b < NodeCount) link_up(b + 1, c);
        son[c] = IdxW'(b);
        c = l;
      end
      c = prnt[c];
    end while (c != 0);
  endfunction

  function automatic void put_byte(logic [ByteW-1:0] v);
    decoded_byte_t e;
    hist[wpos] = v;
    wpos = wpos + 1'b1;
    if (n_out != 32'hFFFF_FFFF) n_out = n_out + 1;
    e.data = v;
    e.last = 1'b0;
    e.done = (n_out >= total_len);
    byte_q.push_back(e);
  endfunction

  function automatic void mark_last();
    decoded_byte_t e;
    e = byte_q.pop_back();
    e.last = 1'b1;
    byte_q.push_back(e);
  endfunction

  // Advance the decoder by one compressed bit
  function automatic void decode_bit(logic b_in);
    logic b;
    pos_split_t sp;
    logic [WinAw-1:0] start;
    int unsigned nxt, sym, n;
    if (n_out >= total_len) return;
    b = b_in;
    if (n_bits >= {comp_len, 3'b000}) b = 1'b0;
    if (n_bits != {BitsW{1'b1}}) n_bits = n_bits + 1;
    case (phase)
      PhByte: begin
        pos_sh = {8'h00, pos_sh[6:0], b};
        if (pos_left > 0) pos_left--;
        if (pos_left == 0) begin
          sp = split_byte(pos_sh[7:0]);
          pos_sh = {4'h0, sp.hi, pos_sh[5:0]};
          pos_left = sp.extra;
          phase = PhExtra;
        end
      end
      PhExtra: begin
        pos_sh = {4'h0, pos_sh[11:6], pos_sh[4:0], b};
        if (pos_left > 0) pos_left--;
        if (pos_left == 0) begin
          start = wpos - pos_sh[11:0] - 1'b1;
          n = 0;
          for (int unsigned k = 0; k < match_len && k < MaxMatch; k++) begin
            put_byte(hist[WinAw'(start + k)]);
            n++;
          end
          phase = PhSymbol;
          pos_sh = '0;
          match_len = '0;
          if (n > 0) mark_last();
        end
      end
      default: begin
        phase = PhSymbol;
        if (32'(walk) + 32'(b) >= NodeCount) begin
          walk = son[RootNode];
        end else begin
          nxt = son[walk + b];
          if (nxt < NodeCount) begin
            walk = IdxW'(nxt);
          end else begin
            sym = nxt - NodeCount;
            if (sym >= SymCount) sym = SymCount - 1;
            count_symbol(sym);
            walk = son[RootNode];
            if (sym < LitCount) begin
              put_byte(ByteW'(sym));
              mark_last();
            end else begin
              match_len = LenW'(sym - LenBias);
              phase = PhByte;
              pos_sh = '0;
              pos_left = 4'd8;
            end
          end
        end
      end
    endcase
  endfunction

  assign pending_o = byte_q.size();

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_byte_t e;
    if (!rst_ni) begin
      init_tree();
      byte_q.delete();
      bytes_seen_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegTotalLength) total_len = cfg_data_i;
        else if (cfg_index_i == RegCompLength) comp_len = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        bytes_seen_o <= bytes_seen_o + 1;
        if (byte_q.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: unexpected byte %02h", $realtime, out_byte_i);
          errors_o <= errors_o + 1;
        end else begin
          e = byte_q.pop_front();
          if (e.data !== out_byte_i || e.last !== last_of_run_i ||
              e.done !== stream_done_i) begin
            if (errors_o < 10)
              $display("%0t: mismatch exp byte=%02h last=%0b done=%0b got byte=%02h last=%0b done=%0b",
                       $realtime, e.data, e.last, e.done,
                       out_byte_i, last_of_run_i, stream_done_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_bit(in_bit_i);
    end
  end

endmodule

FILE: bench/tb_lzss_adaptive_huffman_decoder.sv
// Testbench top for the adaptive Huffman LZSS decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_lzss_adaptive_huffman_decoder;
  import lzhd_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 3000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = RegTotalLength;
  logic [CntW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_bit = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ByteW-1:0]   out_byte;
  logic               last_of_run;
  logic               stream_done;

  int pending, bytes_seen, errors;
  int bits_sent = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  lzss_adaptive_huffman_decoder dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_bit_i(in_bit),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_byte_o(out_byte),
    .last_of_run_o(last_of_run), .stream_done_o(stream_done)
  );

  lzhd_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_bit_i(in_bit),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_byte_i(out_byte),
    .last_of_run_i(last_of_run), .stream_done_i(stream_done),
    .pending_o(pending), .bytes_seen_o(bytes_seen), .errors_o(errors)
  );

  // Receiver: random ready modes, plus one long hold-off on request
  int hold_cnt = 0;
  int mode_cnt = 0;
  int mode = 0;
  logic hold_used = 1'b0;
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        mode <= $urandom_range(0, 2);
        mode_cnt <= $urandom_range(20, 120);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // One bit transaction; sender sometimes idles between bursts
  task automatic send_bit(logic b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_bit <= b;
    do @(posedge clk); while (!in_ready);
    bits_sent++;
  endtask

  // One register write; valid drops for a cycle before the next one
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until all predicted bytes arrived and the block is idle again
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ready) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero lengths: bits are accepted but nothing is decoded
    write_reg(RegTotalLength, 32'd0);
    write_reg(RegCompLength, 32'd0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    drain();

    // Directed: right-most walk gives the longest match, then far distance, then literals
    write_reg(RegTotalLength, 32'hFFFF_FFFF);
    write_reg(RegCompLength, 32'hFFFF_FFFF);
    repeat (12) send_bit(1'b1);
    repeat (10) send_bit(1'b0);
    drain();

    // Random bits, with one long output stall while input keeps coming
    n = 0;
    while (n < 70) begin
      if (n == 20) hold_req <= 1'b1;
      send_bit($urandom_range(0, 1));
      n++;
    end
    drain();

    // Past the compressed data: every bit decodes as zero
    write_reg(RegCompLength, 32'd1);
    repeat (15) send_bit($urandom_range(0, 1));
    drain();

    // Stop a few bytes ahead, then resume
    write_reg(RegCompLength, 32'hFFFF_FFFF);
    write_reg(RegTotalLength, 32'(bytes_seen + 3));
    repeat (20) send_bit($urandom_range(0, 1));
    drain();
    write_reg(RegTotalLength, 32'hFFFF_FFFF);
    repeat (20) send_bit($urandom_range(0, 1));
    drain();

    $display("Fed %0d compressed bits through length limits, zero-fill and a long stall;",
             bits_sent);
    $display("checked %0d decoded bytes, %0d mismatches.", bytes_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
